// ===== hdl/rbc_pkg.sv =====
// Package for the RNS basis conversion block: item types, table codes and
// the layout of the flat table memory. Used by every file in hdl/.
package rbc_pkg;

	localparam int NUM_P_DEF = 4;
	localparam int NUM_Q_DEF = 8;
	localparam int WORD_W    = 64;

	// Table select codes.
	localparam logic [2:0] SEL_P_PRIMES  = 3'd0;
	localparam logic [2:0] SEL_Q_PRIMES  = 3'd1;
	localparam logic [2:0] SEL_Q_HAT_INV = 3'd2;
	localparam logic [2:0] SEL_Q_HAT_P   = 3'd3;
	localparam logic [2:0] SEL_P_HAT_INV = 3'd4;
	localparam logic [2:0] SEL_P_HAT_Q   = 3'd5;
	localparam logic [2:0] SEL_P_INV_Q   = 3'd6;

	// Item modes and conversion directions.
	localparam logic MODE_TABLE   = 1'b0;
	localparam logic MODE_RESIDUE = 1'b1;
	localparam logic DIR_UP       = 1'b0;
	localparam logic DIR_DOWN     = 1'b1;

	// Configuration register indexes.
	localparam logic CFG_DIRECTION = 1'b0;
	localparam logic CFG_Q_LEVEL   = 1'b1;

	typedef struct packed {
		logic              mode;
		logic [2:0]        table_select;
		logic [7:0]        table_address;
		logic [WORD_W-1:0] word_value;
	} in_item_t;

	typedef struct packed {
		logic [WORD_W-1:0] residue_out;
		logic [2:0]        prime_index;
		logic              last_of_coefficient;
	} out_item_t;

	typedef struct packed {
		logic              we;
		logic [2:0]        sel;
		logic [7:0]        addr;
		logic [WORD_W-1:0] data;
	} tbl_wr_t;

	typedef struct packed {
		logic              start;
		logic              bypass;
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
		logic [WORD_W-1:0] m;
	} mm_req_t;

	typedef struct packed {
		logic              done;
		logic [WORD_W-1:0] r;
	} mm_rsp_t;

	// Number of words in one table.
	function automatic int tbl_depth(logic [2:0] sel, int np, int nq);
		int d;
		d = 0;
		case (sel)
			SEL_P_PRIMES:  d = np;
			SEL_Q_PRIMES:  d = nq;
			SEL_Q_HAT_INV: d = nq * nq;
			SEL_Q_HAT_P:   d = np * nq * nq;
			SEL_P_HAT_INV: d = np;
			SEL_P_HAT_Q:   d = nq * np;
			SEL_P_INV_Q:   d = nq;
			default:       d = 0;
		endcase
		return d;
	endfunction

	// First word of one table in the flat memory.
	function automatic int tbl_base(logic [2:0] sel, int np, int nq);
		int b;
		b = 0;
		case (sel)
			SEL_P_PRIMES:  b = 0;
			SEL_Q_PRIMES:  b = np;
			SEL_Q_HAT_INV: b = np + nq;
			SEL_Q_HAT_P:   b = np + nq + nq * nq;
			SEL_P_HAT_INV: b = np + nq + nq * nq + np * nq * nq;
			SEL_P_HAT_Q:   b = 2 * np + nq + nq * nq + np * nq * nq;
			SEL_P_INV_Q:   b = 2 * np + nq + nq * nq + np * nq * nq + nq * np;
			default:       b = 0;
		endcase
		return b;
	endfunction

	function automatic int tbl_total(int np, int nq);
		return 2 * np + 2 * nq + nq * nq + np * nq * nq + nq * np;
	endfunction

endpackage

// ===== hdl/rbc_tables.sv =====
// Flat table memory holding the primes and all conversion tables.
// One write port decoded from table items, one registered read port. Uses rbc_pkg.
module rbc_tables #(
	parameter int NUM_P = rbc_pkg::NUM_P_DEF,
	parameter int NUM_Q = rbc_pkg::NUM_Q_DEF,
	localparam int TOTAL = rbc_pkg::tbl_total(NUM_P, NUM_Q),
	localparam int ADDR_W = $clog2(TOTAL)
) (
	input  logic                        clk,
	input  rbc_pkg::tbl_wr_t            wr,
	input  logic [ADDR_W-1:0]           rd_addr,
	output logic [rbc_pkg::WORD_W-1:0]  rd_data
);
	import rbc_pkg::*;

	logic [WORD_W-1:0] mem_q [TOTAL];
	logic [WORD_W-1:0] rd_data_q;
	logic              wr_ok;
	logic [ADDR_W-1:0] wr_idx;

	// Writes beyond a table's depth, or to an unused select, are dropped.
	always_comb begin
		wr_ok  = wr.we && (int'(wr.addr) < tbl_depth(wr.sel, NUM_P, NUM_Q));
		wr_idx = ADDR_W'(tbl_base(wr.sel, NUM_P, NUM_Q) + int'(wr.addr));
	end

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem_q[wr_idx] <= wr.data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hdl/rbc_mulmod.sv =====
// Shared modular multiplier: 128-bit product from four 32x32 partial products,
// then a one-bit-per-cycle shift-subtract reduction. Uses rbc_pkg.
module rbc_mulmod (
	input  logic              clk,
	input  logic              arst_n,
	input  rbc_pkg::mm_req_t  req,
	output rbc_pkg::mm_rsp_t  rsp
);
	import rbc_pkg::*;

	localparam logic [1:0] MS_IDLE = 2'd0;
	localparam logic [1:0] MS_MUL  = 2'd1;
	localparam logic [1:0] MS_RED  = 2'd2;

	logic [1:0]          st_q;
	logic [1:0]          k_q;
	logic [6:0]          cnt_q;
	logic                done_q;
	logic [WORD_W-1:0]   a_q, b_q, m_q, r_q;
	logic [2*WORD_W-1:0] prod_q;

	logic [31:0]         op_x, op_y;
	logic [63:0]         pp;
	logic [127:0]        pp_sh;
	logic [WORD_W-1:0]   rn;

	// One partial product per cycle, placed at its weight.
	always_comb begin
		op_x  = a_q[31:0];
		op_y  = b_q[31:0];
		pp_sh = '0;
		unique case (k_q)
			2'd0: begin
				op_x = a_q[31:0];
				op_y = b_q[31:0];
			end
			2'd1: begin
				op_x = a_q[31:0];
				op_y = b_q[63:32];
			end
			2'd2: begin
				op_x = a_q[63:32];
				op_y = b_q[31:0];
			end
			2'd3: begin
				op_x = a_q[63:32];
				op_y = b_q[63:32];
			end
		endcase
		pp = op_x * op_y;
		unique case (k_q)
			2'd0: pp_sh = {64'd0, pp};
			2'd1, 2'd2: pp_sh = {32'd0, pp, 32'd0};
			2'd3: pp_sh = {pp, 64'd0};
		endcase
	end

	// Reduction step: shift in the next bit; subtract m on overflow or rn >= m.
	always_comb begin
		rn = {r_q[WORD_W-2:0], prod_q[2*WORD_W-1]};
		if (r_q[WORD_W-1] || (rn >= m_q)) begin
			rn = rn - m_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= MS_IDLE;
			k_q    <= '0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				MS_IDLE: begin
					if (req.start) begin
						a_q   <= req.a;
						b_q   <= req.b;
						m_q   <= req.m;
						r_q   <= '0;
						cnt_q <= '0;
						k_q   <= '0;
						if (req.bypass) begin
							prod_q <= {64'd0, req.a};
							st_q   <= MS_RED;
						end else begin
							prod_q <= '0;
							st_q   <= MS_MUL;
						end
					end
				end
				MS_MUL: begin
					prod_q <= prod_q + pp_sh;
					k_q    <= k_q + 2'd1;
					if (k_q == 2'd3) begin
						st_q <= MS_RED;
					end
				end
				MS_RED: begin
					r_q    <= rn;
					prod_q <= {prod_q[2*WORD_W-2:0], 1'b0};
					cnt_q  <= cnt_q + 7'd1;
					if (cnt_q == 7'd127) begin
						done_q <= 1'b1;
						st_q   <= MS_IDLE;
					end
				end
				default: st_q <= MS_IDLE;
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.r    = r_q;

endmodule

// ===== hdl/rns_basis_conversion.sv =====
// RNS fast basis conversion, top level: sequencer, configuration, output register.
// Instantiates rbc_tables and rbc_mulmod; uses rbc_pkg.
// Each modular product runs the partial products and then the reduction in the shared unit;
// each reduction of a sum (bypass) runs the reduction only. An up-mode residue
// takes about 1 + 3*NUM_P such operations, a down-mode P residue one, a Q residue 3*NUM_P+3.
// Throughput: one item at a time; a table write leaves the block idle.
// Reset: asynchronous, clears control, configuration and partial sums; tables stay undefined.
module rns_basis_conversion #(
	parameter int NUM_P = rbc_pkg::NUM_P_DEF,
	parameter int NUM_Q = rbc_pkg::NUM_Q_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  rbc_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_stall,
	output rbc_pkg::out_item_t out_item,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [3:0]         cfg_data
);
	import rbc_pkg::*;

	localparam int ADDR_W = $clog2(tbl_total(NUM_P, NUM_Q));
	localparam int POS_W  = $clog2(NUM_P + NUM_Q + 1);
	localparam int PW     = (NUM_P > 1) ? $clog2(NUM_P) : 1;
	localparam int QW     = (NUM_Q > 1) ? $clog2(NUM_Q) : 1;
	localparam int LW     = $clog2(NUM_Q + 1);

	localparam logic [4:0] ST_IDLE     = 5'd0;
	localparam logic [4:0] ST_U_RD_INV = 5'd1;
	localparam logic [4:0] ST_U_RD_Q   = 5'd2;
	localparam logic [4:0] ST_U_MUL_Y  = 5'd3;
	localparam logic [4:0] ST_U_GET_Y  = 5'd4;
	localparam logic [4:0] ST_U_RD_HP  = 5'd5;
	localparam logic [4:0] ST_U_RD_P   = 5'd6;
	localparam logic [4:0] ST_U_MUL_Z  = 5'd7;
	localparam logic [4:0] ST_U_ADD    = 5'd8;
	localparam logic [4:0] ST_U_STORE  = 5'd9;
	localparam logic [4:0] ST_U_EMIT   = 5'd10;
	localparam logic [4:0] ST_D_RD_PHI = 5'd11;
	localparam logic [4:0] ST_D_RD_P   = 5'd12;
	localparam logic [4:0] ST_D_MUL    = 5'd13;
	localparam logic [4:0] ST_D_STORE  = 5'd14;
	localparam logic [4:0] ST_D_RD_Q   = 5'd15;
	localparam logic [4:0] ST_D_GET_Q  = 5'd16;
	localparam logic [4:0] ST_D_RD_PHQ = 5'd17;
	localparam logic [4:0] ST_D_MUL_Z  = 5'd18;
	localparam logic [4:0] ST_D_ADD    = 5'd19;
	localparam logic [4:0] ST_D_ACC    = 5'd20;
	localparam logic [4:0] ST_D_FIX    = 5'd21;
	localparam logic [4:0] ST_D_RD_PI  = 5'd22;
	localparam logic [4:0] ST_D_MUL_R  = 5'd23;
	localparam logic [4:0] ST_D_EMIT   = 5'd24;
	localparam logic [4:0] ST_OP_GO    = 5'd25;
	localparam logic [4:0] ST_OP_WAIT  = 5'd26;
	localparam logic [4:0] ST_ADD_1    = 5'd27;
	localparam logic [4:0] ST_ADD_2    = 5'd28;

	logic [4:0]        state_q, ret_q, aret_q;
	logic              dir_q;
	logic [3:0]        q_level_q;
	logic [POS_W-1:0]  pos_q;
	logic [PW-1:0]     i_q;
	logic [WORD_W-1:0] ps_q [NUM_P];
	logic [WORD_W-1:0] x_q, a_q, b_q, m_q, y_q, t_q, u_q, sum_q, conv_q;
	logic              byp_q;
	logic              out_valid_q;
	out_item_t         out_item_q;

	logic              in_accept, out_free, out_load;
	logic [LW-1:0]     lvl;
	logic [QW-1:0]     j_idx, qi_idx;
	logic [ADDR_W-1:0] rd_addr;
	logic [WORD_W-1:0] rd_data;
	logic [WORD_W:0]   add_s;
	logic [WORD_W-1:0] add_r;
	logic              i_last, qi_last;
	tbl_wr_t           tbl_wr;
	mm_req_t           mm_req;
	mm_rsp_t           mm_rsp;

	assign in_accept = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_free  = !out_valid_q || !out_stall;
	assign out_load  = ((state_q == ST_U_EMIT) || (state_q == ST_D_EMIT)) && out_free;

	// Level in use, saturated into 1..NUM_Q.
	always_comb begin
		if (q_level_q == 4'd0) begin
			lvl = LW'(1);
		end else if (int'(q_level_q) > NUM_Q) begin
			lvl = LW'(NUM_Q);
		end else begin
			lvl = LW'(q_level_q);
		end
	end

	assign j_idx   = pos_q[QW-1:0];
	assign qi_idx  = QW'(int'(pos_q) - NUM_P);
	assign i_last  = (int'(i_q) == NUM_P - 1);
	assign qi_last = (int'(qi_idx) + 1 == int'(lvl));

	// Modular add of two reduced operands.
	always_comb begin
		add_s = {1'b0, t_q} + {1'b0, mm_rsp.r};
		add_r = add_s[WORD_W-1:0];
		if (add_s[WORD_W] || (add_r >= m_q)) begin
			add_r = add_r - m_q;
		end
	end

	// Table read address for the state that issues a read.
	always_comb begin
		rd_addr = '0;
		unique case (state_q)
			ST_U_RD_INV: rd_addr = ADDR_W'(tbl_base(SEL_Q_HAT_INV, NUM_P, NUM_Q)
				+ (int'(lvl) - 1) * NUM_Q + int'(j_idx));
			ST_U_RD_Q: rd_addr = ADDR_W'(tbl_base(SEL_Q_PRIMES, NUM_P, NUM_Q)
				+ int'(j_idx));
			ST_U_RD_HP: rd_addr = ADDR_W'(tbl_base(SEL_Q_HAT_P, NUM_P, NUM_Q)
				+ (int'(i_q) * NUM_Q + int'(lvl) - 1) * NUM_Q + int'(j_idx));
			ST_U_RD_P: rd_addr = ADDR_W'(tbl_base(SEL_P_PRIMES, NUM_P, NUM_Q) + int'(i_q));
			ST_D_RD_PHI: rd_addr = ADDR_W'(tbl_base(SEL_P_HAT_INV, NUM_P, NUM_Q)
				+ int'(pos_q));
			ST_D_RD_P: rd_addr = ADDR_W'(tbl_base(SEL_P_PRIMES, NUM_P, NUM_Q) + int'(pos_q));
			ST_D_RD_Q: rd_addr = ADDR_W'(tbl_base(SEL_Q_PRIMES, NUM_P, NUM_Q)
				+ int'(qi_idx));
			ST_D_RD_PHQ: rd_addr = ADDR_W'(tbl_base(SEL_P_HAT_Q, NUM_P, NUM_Q)
				+ int'(qi_idx) * NUM_P + int'(i_q));
			ST_D_RD_PI: rd_addr = ADDR_W'(tbl_base(SEL_P_INV_Q, NUM_P, NUM_Q)
				+ int'(qi_idx));
			default: rd_addr = '0;
		endcase
	end

	always_comb begin
		tbl_wr.we   = in_accept && (in_item.mode == MODE_TABLE);
		tbl_wr.sel  = in_item.table_select;
		tbl_wr.addr = in_item.table_address;
		tbl_wr.data = in_item.word_value;
	end

	assign mm_req.start  = (state_q == ST_OP_GO);
	assign mm_req.bypass = byp_q;
	assign mm_req.a      = a_q;
	assign mm_req.b      = b_q;
	assign mm_req.m      = m_q;

	rbc_tables #(
		.NUM_P(NUM_P),
		.NUM_Q(NUM_Q)
	) u_tables (
		.clk    (clk),
		.wr     (tbl_wr),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	rbc_mulmod u_mulmod (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (mm_req),
		.rsp   (mm_rsp)
	);

	// Sequencer, configuration and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ret_q       <= ST_IDLE;
			aret_q      <= ST_IDLE;
			dir_q       <= DIR_UP;
			q_level_q   <= 4'd8;
			pos_q       <= '0;
			i_q         <= '0;
			byp_q       <= 1'b0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < NUM_P; k++) begin
				ps_q[k] <= '0;
			end
		end else begin
			// The output register fills on an emit and empties when its item is taken.
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			// Any register write drops the coefficient in progress.
			if (cfg_we) begin
				if (cfg_index == CFG_DIRECTION) begin
					dir_q <= cfg_data[0];
				end else begin
					q_level_q <= cfg_data;
				end
				pos_q <= '0;
				for (int k = 0; k < NUM_P; k++) begin
					ps_q[k] <= '0;
				end
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_accept && (in_item.mode == MODE_RESIDUE)) begin
						x_q <= in_item.word_value;
						i_q <= '0;
						if (dir_q == DIR_UP) begin
							state_q <= ST_U_RD_INV;
							if (int'(pos_q) >= int'(lvl)) begin
								pos_q <= '0;
								for (int k = 0; k < NUM_P; k++) begin
									ps_q[k] <= '0;
								end
							end
						end else if (int'(pos_q) >= NUM_P + int'(lvl)) begin
							pos_q <= '0;
							for (int k = 0; k < NUM_P; k++) begin
								ps_q[k] <= '0;
							end
							state_q <= ST_D_RD_PHI;
						end else if (int'(pos_q) < NUM_P) begin
							state_q <= ST_D_RD_PHI;
						end else begin
							state_q <= ST_D_RD_Q;
						end
					end
				end

				// Shared-unit call and return.
				ST_OP_GO: state_q <= ST_OP_WAIT;
				ST_OP_WAIT: begin
					if (mm_rsp.done) begin
						state_q <= ret_q;
					end
				end
				ST_ADD_1: begin
					t_q     <= mm_rsp.r;
					a_q     <= u_q;
					byp_q   <= 1'b1;
					ret_q   <= ST_ADD_2;
					state_q <= ST_OP_GO;
				end
				ST_ADD_2: begin
					sum_q   <= add_r;
					state_q <= aret_q;
				end

				// Up conversion.
				ST_U_RD_INV: state_q <= ST_U_RD_Q;
				ST_U_RD_Q: begin
					b_q     <= rd_data;
					state_q <= ST_U_MUL_Y;
				end
				ST_U_MUL_Y: begin
					m_q     <= rd_data;
					a_q     <= x_q;
					byp_q   <= 1'b0;
					ret_q   <= ST_U_GET_Y;
					state_q <= ST_OP_GO;
				end
				ST_U_GET_Y: begin
					y_q     <= mm_rsp.r;
					i_q     <= '0;
					state_q <= ST_U_RD_HP;
				end
				ST_U_RD_HP: state_q <= ST_U_RD_P;
				ST_U_RD_P: begin
					b_q     <= rd_data;
					state_q <= ST_U_MUL_Z;
				end
				ST_U_MUL_Z: begin
					m_q     <= rd_data;
					a_q     <= y_q;
					byp_q   <= 1'b0;
					ret_q   <= ST_U_ADD;
					state_q <= ST_OP_GO;
				end
				ST_U_ADD: begin
					u_q     <= mm_rsp.r;
					a_q     <= ps_q[i_q];
					byp_q   <= 1'b1;
					ret_q   <= ST_ADD_1;
					aret_q  <= ST_U_STORE;
					state_q <= ST_OP_GO;
				end
				ST_U_STORE: begin
					ps_q[i_q] <= sum_q;
					if (i_last) begin
						if (int'(j_idx) + 1 < int'(lvl)) begin
							pos_q   <= pos_q + POS_W'(1);
							state_q <= ST_IDLE;
						end else begin
							i_q     <= '0;
							state_q <= ST_U_EMIT;
						end
					end else begin
						i_q     <= i_q + PW'(1);
						state_q <= ST_U_RD_HP;
					end
				end
				ST_U_EMIT: begin
					if (out_free) begin
						out_item_q.residue_out         <= ps_q[i_q];
						out_item_q.prime_index         <= 3'(i_q);
						out_item_q.last_of_coefficient <= i_last;
						if (i_last) begin
							pos_q <= '0;
							for (int k = 0; k < NUM_P; k++) begin
								ps_q[k] <= '0;
							end
							state_q <= ST_IDLE;
						end else begin
							i_q <= i_q + PW'(1);
						end
					end
				end

				// Down conversion, P residue.
				ST_D_RD_PHI: state_q <= ST_D_RD_P;
				ST_D_RD_P: begin
					b_q     <= rd_data;
					state_q <= ST_D_MUL;
				end
				ST_D_MUL: begin
					m_q     <= rd_data;
					a_q     <= x_q;
					byp_q   <= 1'b0;
					ret_q   <= ST_D_STORE;
					state_q <= ST_OP_GO;
				end
				ST_D_STORE: begin
					ps_q[pos_q[PW-1:0]] <= mm_rsp.r;
					pos_q               <= pos_q + POS_W'(1);
					state_q             <= ST_IDLE;
				end

				// Down conversion, Q residue.
				ST_D_RD_Q: state_q <= ST_D_GET_Q;
				ST_D_GET_Q: begin
					m_q     <= rd_data;
					conv_q  <= '0;
					i_q     <= '0;
					state_q <= ST_D_RD_PHQ;
				end
				ST_D_RD_PHQ: state_q <= ST_D_MUL_Z;
				ST_D_MUL_Z: begin
					b_q     <= rd_data;
					a_q     <= ps_q[i_q];
					byp_q   <= 1'b0;
					ret_q   <= ST_D_ADD;
					state_q <= ST_OP_GO;
				end
				ST_D_ADD: begin
					u_q     <= mm_rsp.r;
					a_q     <= conv_q;
					byp_q   <= 1'b1;
					ret_q   <= ST_ADD_1;
					aret_q  <= ST_D_ACC;
					state_q <= ST_OP_GO;
				end
				ST_D_ACC: begin
					conv_q <= sum_q;
					if (i_last) begin
						state_q <= ST_D_FIX;
					end else begin
						i_q     <= i_q + PW'(1);
						state_q <= ST_D_RD_PHQ;
					end
				end
				ST_D_FIX: begin
					u_q     <= x_q;
					a_q     <= m_q - conv_q;
					byp_q   <= 1'b1;
					ret_q   <= ST_ADD_1;
					aret_q  <= ST_D_RD_PI;
					state_q <= ST_OP_GO;
				end
				ST_D_RD_PI: state_q <= ST_D_MUL_R;
				ST_D_MUL_R: begin
					a_q     <= rd_data;
					b_q     <= sum_q;
					byp_q   <= 1'b0;
					ret_q   <= ST_D_EMIT;
					state_q <= ST_OP_GO;
				end
				ST_D_EMIT: begin
					if (out_free) begin
						out_item_q.residue_out         <= mm_rsp.r;
						out_item_q.prime_index         <= 3'(qi_idx);
						out_item_q.last_of_coefficient <= qi_last;
						if (qi_last) begin
							pos_q <= '0;
							for (int k = 0; k < NUM_P; k++) begin
								ps_q[k] <= '0;
							end
						end else begin
							pos_q <= pos_q + POS_W'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

// ===== hdl/rbc_checker.sv =====
// Port-level checks for rns_basis_conversion, attached by the bind below.
// Depends on rbc_pkg and the top level's ports.
module rbc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input rbc_pkg::in_item_t  in_item,
	input logic               out_valid,
	input logic               out_stall,
	input rbc_pkg::out_item_t out_item
);
	import rbc_pkg::*;

	// A residue item keeps the block busy on the next cycle.
	a_residue_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && (in_item.mode == MODE_RESIDUE)) |=> in_stall)
		else $error("block ready right after a residue item");

	// A table write completes at once.
	a_table_write_fast: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && (in_item.mode == MODE_TABLE)) |=> !in_stall)
		else $error("block busy after a table write");

	// A new result only comes out of a busy block.
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared while the block was idle");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_item)))
		else $error("stalled result changed");

endmodule

bind rns_basis_conversion rbc_checker u_rbc_checker (.*);
